@@ rtl/core/dcfb_pkg.sv @@
package dcfb_pkg;

   localparam int IDX_W = 6;

   localparam logic [7:0]  HEADER_BYTE = 8'hFD;
   localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;

   // payload_length must exceed these for the optional bytes 23..26
   localparam logic [15:0] LEN_SUB  = 16'h0012;
   localparam logic [15:0] LEN_RESA = 16'h0013;
   localparam logic [15:0] LEN_RESB = 16'h0014;
   localparam logic [15:0] LEN_REFR = 16'h0015;

   // first byte covered by the CRC
   localparam logic [IDX_W-1:0] CRC_START = 6'd5;

   typedef struct packed {
      logic [15:0] message_id;
      logic [7:0]  display_mode;
      logic [7:0]  sub_mode;
      logic [7:0]  res_param_a;
      logic [7:0]  res_param_b;
      logic [7:0]  refresh_code;
      logic [15:0] payload_length;
      logic [31:0] sequence_number;
   } fields_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic crc_step;
      logic clear_cnt;
      logic emit;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic crc_done;
      logic emit_last;
   } sts_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data);
      logic [31:0] c;
      c = crc_in ^ {24'd0, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_byte(input logic [IDX_W-1:0] idx,
                                             input fields_type        f,
                                             input logic [31:0]       crc);
      logic [7:0] v;
      case (idx)
         6'd0:  v = HEADER_BYTE;
         6'd1:  v = crc[7:0];
         6'd2:  v = crc[15:8];
         6'd3:  v = crc[23:16];
         6'd4:  v = crc[31:24];
         6'd5:  v = f.payload_length[7:0];
         6'd6:  v = f.payload_length[15:8];
         6'd7:  v = f.sequence_number[7:0];
         6'd8:  v = f.sequence_number[15:8];
         6'd9:  v = f.sequence_number[23:16];
         6'd10: v = f.sequence_number[31:24];
         6'd15: v = f.message_id[7:0];
         6'd16: v = f.message_id[15:8];
         6'd22: v = f.display_mode;
         6'd23: v = (f.payload_length > LEN_SUB)  ? f.sub_mode     : 8'd0;
         6'd24: v = (f.payload_length > LEN_RESA) ? f.res_param_a  : 8'd0;
         6'd25: v = (f.payload_length > LEN_RESB) ? f.res_param_b  : 8'd0;
         6'd26: v = (f.payload_length > LEN_REFR) ? f.refresh_code : 8'd0;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

endpackage

@@ rtl/core/dcfb_ctrl.sv @@
module dcfb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dcfb_pkg::sts_type sts,
   output dcfb_pkg::ctl_type ctl
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CRC  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            if (sts.crc_done) begin
               ctl.clear_cnt = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               ctl.crc_step = 1'b1;
            end
         end
         ST_EMIT: begin
            ctl.emit = 1'b1;
            if (sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

@@ rtl/core/dcfb_datapath.sv @@
module dcfb_datapath #(
   parameter int FRAME_BYTES = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dcfb_pkg::ctl_type          ctl,
   output dcfb_pkg::sts_type          sts,
   input  dcfb_pkg::fields_type       req,
   output logic                       rsp_strobe,
   output logic [dcfb_pkg::IDX_W-1:0] rsp_byte_index,
   output logic [7:0]                 rsp_byte_value,
   output logic                       rsp_last_byte,
   output logic                       rsp_length_clamped
);

   localparam int W = dcfb_pkg::IDX_W;
   localparam logic [W-1:0]  SPAN_MAX  = W'(FRAME_BYTES - 5);
   localparam logic [W-1:0]  LAST_IDX  = W'(FRAME_BYTES - 1);
   localparam logic [15:0]   SPAN_MAX16 = 16'(FRAME_BYTES - 5);

   dcfb_pkg::fields_type fields_ff;
   logic [W-1:0]         span_ff;
   logic                 clamped_ff;
   logic [W-1:0]         cnt_ff;
   logic [31:0]          crc_ff;

   logic                 strobe_ff;
   logic [W-1:0]         idx_ff;
   logic [7:0]           value_ff;
   logic                 last_ff;

   logic [W-1:0]         crc_pos;
   logic [7:0]           crc_data;
   logic                 long_len;

   assign long_len = (req.payload_length > SPAN_MAX16);
   assign crc_pos  = cnt_ff + dcfb_pkg::CRC_START;
   // bytes 1..4 read as zero while the CRC runs
   assign crc_data = dcfb_pkg::frame_byte(crc_pos, fields_ff, 32'd0);

   assign sts.crc_done  = (cnt_ff == span_ff);
   assign sts.emit_last = (cnt_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         fields_ff  <= req;
         span_ff    <= long_len ? SPAN_MAX : req.payload_length[W-1:0];
         clamped_ff <= long_len;
         crc_ff     <= dcfb_pkg::CRC_INIT;
      end else if (ctl.crc_step) begin
         crc_ff     <= dcfb_pkg::crc_byte(crc_ff, crc_data);
      end
      if (ctl.emit) begin
         idx_ff   <= cnt_ff;
         value_ff <= dcfb_pkg::frame_byte(cnt_ff, fields_ff,
                                          crc_ff ^ dcfb_pkg::CRC_INIT);
         last_ff  <= sts.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.emit;
         if (ctl.load || ctl.clear_cnt) begin
            cnt_ff <= '0;
         end else if (ctl.crc_step || ctl.emit) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_byte_index     = idx_ff;
   assign rsp_byte_value     = value_ff;
   assign rsp_last_byte      = last_ff;
   assign rsp_length_clamped = clamped_ff;

endmodule

@@ rtl/core/display_command_frame_builder_unit.sv @@
// Channel   | Ports                         | Handshake
// ----------+-------------------------------+------------------------------------
// request   | start, busy, req_*            | taken when start=1 and busy=0
// response  | rsp_strobe, rsp_*             | one byte per strobe cycle, no stall
//
// A transaction loads the request and runs the CRC over span bytes, span being
// min(payload_length, FRAME_BYTES-5): the CRC pass handles one frame byte per
// cycle through the 8-step bit loop, then the frame goes out one byte a cycle.
// Bytes appear in the cycle after they are formed (registered outputs).
// Synchronous active-high reset returns the controller to idle and drops the
// strobe; payload registers are not reset. The receiver has no backpressure.
module display_command_frame_builder_unit #(
   parameter int FRAME_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_message_id,
   input  logic [7:0]  req_display_mode,
   input  logic [7:0]  req_sub_mode,
   input  logic [7:0]  req_res_param_a,
   input  logic [7:0]  req_res_param_b,
   input  logic [7:0]  req_refresh_code,
   input  logic [15:0] req_payload_length,
   input  logic [31:0] req_sequence_number,

   output logic        rsp_strobe,
   output logic [5:0]  rsp_byte_index,
   output logic [7:0]  rsp_byte_value,
   output logic        rsp_last_byte,
   output logic        rsp_length_clamped
);

   dcfb_pkg::ctl_type    ctl;
   dcfb_pkg::sts_type    sts;
   dcfb_pkg::fields_type req;

   // bundle the request fields for the datapath capture register
   assign req.message_id      = req_message_id;
   assign req.display_mode    = req_display_mode;
   assign req.sub_mode        = req_sub_mode;
   assign req.res_param_a     = req_res_param_a;
   assign req.res_param_b     = req_res_param_b;
   assign req.refresh_code    = req_refresh_code;
   assign req.payload_length  = req_payload_length;
   assign req.sequence_number = req_sequence_number;

   // sequencer: idle -> CRC pass -> byte emission
   dcfb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .ctl   (ctl)
   );

   // field capture, running CRC, byte counter and output registers
   dcfb_datapath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .sts                (sts),
      .req                (req),
      .rsp_strobe         (rsp_strobe),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_byte_value     (rsp_byte_value),
      .rsp_last_byte      (rsp_last_byte),
      .rsp_length_clamped (rsp_length_clamped)
   );

endmodule

@@ tb/testbench.sv @@
module testbench;

   localparam int FRAME_BYTES   = 64;
   // CRC never runs past the end of the frame
   localparam int SPAN_MAX      = FRAME_BYTES - 5;
   localparam int RANDOM_ITEMS  = 310;
   // drain time, longer than the worst-case transaction
   localparam int DRAIN_CYCLES  = 2 * FRAME_BYTES + 32;
   localparam int MAX_REPORTS   = 10;
   localparam int MAX_GAP       = 9;

   // one frame byte as it should show up on the rsp_ ports
   typedef struct {
      logic [5:0] index;
      logic [7:0] value;
      logic       last;
      logic       clamped;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [15:0] req_message_id      = '0;
   logic [7:0]  req_display_mode    = '0;
   logic [7:0]  req_sub_mode        = '0;
   logic [7:0]  req_res_param_a     = '0;
   logic [7:0]  req_res_param_b     = '0;
   logic [7:0]  req_refresh_code    = '0;
   logic [15:0] req_payload_length  = '0;
   logic [31:0] req_sequence_number = '0;
   logic        rsp_strobe;
   logic [5:0]  rsp_byte_index;
   logic [7:0]  rsp_byte_value;
   logic        rsp_last_byte;
   logic        rsp_length_clamped;

   // frame bytes still owed by the block, oldest first
   frame_beat_type pending_bytes[$];
   int             failures = 0;

   display_command_frame_builder_unit #(
      .FRAME_BYTES(FRAME_BYTES)
   ) DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_message_id      (req_message_id),
      .req_display_mode    (req_display_mode),
      .req_sub_mode        (req_sub_mode),
      .req_res_param_a     (req_res_param_a),
      .req_res_param_b     (req_res_param_b),
      .req_refresh_code    (req_refresh_code),
      .req_payload_length  (req_payload_length),
      .req_sequence_number (req_sequence_number),
      .rsp_strobe          (rsp_strobe),
      .rsp_byte_index      (rsp_byte_index),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_last_byte       (rsp_last_byte),
      .rsp_length_clamped  (rsp_length_clamped)
   );

   always #4 clock = ~clock;

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   // Build the whole frame for one command and queue its bytes.
   task automatic predict_frame(input dcfb_pkg::fields_type f);
      logic [7:0]     img [FRAME_BYTES];
      logic [31:0]    crc;
      int             span;
      logic           clamped;
      frame_beat_type beat;
      foreach (img[k]) img[k] = 8'h00;
      img[0] = dcfb_pkg::HEADER_BYTE;
      {img[6], img[5]}                  = f.payload_length;
      {img[10], img[9], img[8], img[7]} = f.sequence_number;
      {img[16], img[15]}                = f.message_id;
      img[22] = f.display_mode;
      // optional bytes: each needs a strictly longer length than the one before
      if (f.payload_length > dcfb_pkg::LEN_SUB)  img[23] = f.sub_mode;
      if (f.payload_length > dcfb_pkg::LEN_RESA) img[24] = f.res_param_a;
      if (f.payload_length > dcfb_pkg::LEN_RESB) img[25] = f.res_param_b;
      if (f.payload_length > dcfb_pkg::LEN_REFR) img[26] = f.refresh_code;
      // length field keeps the raw value; only the CRC span saturates
      clamped = (f.payload_length > SPAN_MAX);
      span    = clamped ? SPAN_MAX : int'(f.payload_length);
      // reflected CRC-32, bytes 1..4 still zero here
      crc = dcfb_pkg::CRC_INIT;
      for (int n = 0; n < span; n++) begin
         crc = crc ^ {24'd0, img[5 + n]};
         for (int b = 0; b < 8; b++) begin
            crc = (crc >> 1) ^ (crc[0] ? dcfb_pkg::CRC_POLY : 32'd0);
         end
      end
      crc = ~crc;
      {img[4], img[3], img[2], img[1]} = crc;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         beat.index   = k[5:0];
         beat.value   = img[k];
         beat.last    = (k == FRAME_BYTES - 1);
         beat.clamped = clamped;
         pending_bytes.push_back(beat);
      end
   endtask

   // One request transaction. start is left high after acceptance so the next
   // call can follow with no gap; a gap lowers it first.
   task automatic send_command(input dcfb_pkg::fields_type f, input int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_message_id      <= f.message_id;
      req_display_mode    <= f.display_mode;
      req_sub_mode        <= f.sub_mode;
      req_res_param_a     <= f.res_param_a;
      req_res_param_b     <= f.res_param_b;
      req_refresh_code    <= f.refresh_code;
      req_payload_length  <= f.payload_length;
      req_sequence_number <= f.sequence_number;
      // busy read right after the edge is its value at the edge
      do @(posedge clock); while (busy);
      predict_frame(f);
   endtask

   function automatic dcfb_pkg::fields_type random_command(input logic [15:0] len);
      dcfb_pkg::fields_type f;
      f.message_id      = 16'($urandom_range(0, 16'hFFFF));
      f.display_mode    = 8'($urandom_range(0, 8'hFF));
      f.sub_mode        = 8'($urandom_range(0, 8'hFF));
      f.res_param_a     = 8'($urandom_range(0, 8'hFF));
      f.res_param_b     = 8'($urandom_range(0, 8'hFF));
      f.refresh_code    = 8'($urandom_range(0, 8'hFF));
      f.payload_length  = len;
      f.sequence_number = $urandom;
      return f;
   endfunction

   // all-zero, all-one and checkerboard fields; zero length gives a zero CRC
   task automatic test_field_extremes;
      dcfb_pkg::fields_type f;
      f = '0;
      send_command(f, MAX_GAP);
      f = '1;
      send_command(f, MAX_GAP);
      f = {16'hA5A5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 16'h003B, 32'hA5A55A5A};
      send_command(f, MAX_GAP);
      f = {16'h5A5A, 8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 16'h0016, 32'h5A5AA5A5};
      send_command(f, MAX_GAP);
   endtask

   // lengths around the thresholds of the optional bytes 23..26
   task automatic test_optional_bytes;
      for (int len = dcfb_pkg::LEN_SUB; len <= dcfb_pkg::LEN_REFR + 1; len++) begin
         send_command(random_command(len[15:0]), MAX_GAP);
      end
   endtask

   // CRC span below, at and above saturation, with short spans too
   task automatic test_length_clamp;
      logic [15:0] lens [6] = '{16'd1, 16'd58, 16'd59, 16'd60, 16'd256, 16'h8000};
      foreach (lens[i]) send_command(random_command(lens[i]), MAX_GAP);
   endtask

   // transactions with start held high throughout
   task automatic test_back_to_back;
      repeat (6) send_command(random_command(16'($urandom_range(0, 70))), 0);
   endtask

   // random commands; stretches of back-to-back traffic among idle-heavy ones
   task automatic test_random_commands;
      int          max_gap;
      logic [15:0] len;
      max_gap = MAX_GAP;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 20 == 0) max_gap = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: len = 16'($urandom_range(0, SPAN_MAX));
            4, 5:       len = 16'($urandom_range(dcfb_pkg::LEN_SUB - 2,
                                                 dcfb_pkg::LEN_REFR + 2));
            6, 7:       len = 16'($urandom_range(SPAN_MAX, 255));
            default:    len = 16'($urandom_range(0, 16'hFFFF));
         endcase
         send_command(random_command(len), max_gap);
      end
   endtask

   // Response checker: a byte is taken at every strobe edge, no backpressure.
   always @(posedge clock) begin : check_bytes
      frame_beat_type want;
      if (!reset && rsp_strobe) begin
         if (pending_bytes.size() == 0) begin
            log_failure($sformatf("unexpected byte: idx %0d val %02h last %b clamp %b",
                                  rsp_byte_index, rsp_byte_value, rsp_last_byte,
                                  rsp_length_clamped));
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_byte_index !== want.index || rsp_byte_value !== want.value ||
                rsp_last_byte !== want.last || rsp_length_clamped !== want.clamped) begin
               log_failure($sformatf({"byte mismatch: want idx %0d val %02h last %b ",
                                      "clamp %b, got idx %0d val %02h last %b clamp %b"},
                  want.index, want.value, want.last, want.clamped,
                  rsp_byte_index, rsp_byte_value, rsp_last_byte, rsp_length_clamped));
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes;
      test_optional_bytes;
      test_length_clamp;
      test_back_to_back;
      test_random_commands;
      start <= 1'b0;
      // let the last frame drain, then watch for stray strobes
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_bytes.size() != 0) begin
         log_failure($sformatf("%0d frame bytes never arrived", pending_bytes.size()));
      end
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
